// ----- hw/rtl/positional_insert_delete_array_macros.svh -----
// ----------------------------------------------------------------------------
// Positional insert/delete array: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH

// same-cycle implication
`define PIDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pida_pkg.sv -----
// ----------------------------------------------------------------------------
// pida_pkg
// Types and constants shared by the positional insert/delete array.
// ----------------------------------------------------------------------------
`default_nettype none

package pida_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_READ,
		OP_INSERT,
		OP_DELETE,
		OP_IDLE
	} op_e;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY,
		ST_BADPOS
	} status_e;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_READ,
		CMD_INSERT,
		CMD_DELETE
	} cmd_kind_e;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SHIFT,
		BK_DRAIN,
		BK_PLACE,
		BK_DONE
	} bk_state_e;

	typedef struct packed {
		logic [1:0]               operation;
		logic [CNT_W-1:0]         position;
		logic signed [DATA_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		status_e                  status;
		logic signed [DATA_W-1:0] value_out;
		logic [CNT_W-1:0]         fill_count;
	} rsp_t;

	typedef struct packed {
		cmd_kind_e                kind;
		status_e                  status;
		logic [CNT_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         count_before;
		logic [CNT_W-1:0]         count_after;
	} cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/positional_insert_delete_array.sv -----
// An error request goes straight to the result; a read or delete passes through the shift and
//   drain states; an insert adds a placement write, and an append goes straight to that write.
// The back end holds one request at a time; the single RAM write port shifts one entry per
//   cycle while the back end is in its shift state.
// Reset: fill count cleared, queues empty; entry storage is not cleared.
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array with insert, delete and read by position.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_array #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire pida_pkg::req_t req,
	output logic                empty,
	input  wire logic           pop,
	output pida_pkg::rsp_t      rsp
);

	logic           q_push;
	logic           q_full;
	pida_pkg::cmd_t q_cmd;
	logic           q_valid;
	logic           q_pop;
	pida_pkg::cmd_t q_head;

	pida_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.q_push (q_push),
		.q_full (q_full),
		.q_cmd  (q_cmd)
	);

	pida_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	pida_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/pida_ram.sv -----
// ----------------------------------------------------------------------------
// pida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pida_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pida_front.sv -----
// ----------------------------------------------------------------------------
// pida_front
// Accept request beats, track the fill count and classify each request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_delete_array_macros.svh"

module pida_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire pida_pkg::req_t req,
	output logic                q_push,
	input  wire logic           q_full,
	output pida_pkg::cmd_t      q_cmd
);

	localparam int CW = pida_pkg::CNT_W;

	logic [CW-1:0] count_q;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_cmd              = '0;
		q_cmd.kind         = pida_pkg::CMD_NONE;
		q_cmd.status       = pida_pkg::ST_OK;
		q_cmd.position     = req.position;
		q_cmd.value        = req.value_in;
		q_cmd.count_before = count_q;
		q_cmd.count_after  = count_q;
		unique case (pida_pkg::op_e'(req.operation))
			pida_pkg::OP_READ: begin
				if (count_q == '0) begin
					q_cmd.status = pida_pkg::ST_EMPTY;
				end else if (req.position >= count_q) begin
					q_cmd.status = pida_pkg::ST_BADPOS;
				end else begin
					q_cmd.kind = pida_pkg::CMD_READ;
				end
			end
			pida_pkg::OP_INSERT: begin
				if (count_q == CW'(pida_pkg::CAPACITY)) begin
					q_cmd.status = pida_pkg::ST_FULL;
				end else if (req.position > count_q) begin
					q_cmd.status = pida_pkg::ST_BADPOS;
				end else begin
					q_cmd.kind        = pida_pkg::CMD_INSERT;
					q_cmd.count_after = count_q + CW'(1);
				end
			end
			pida_pkg::OP_DELETE: begin
				if (count_q == '0) begin
					q_cmd.status = pida_pkg::ST_EMPTY;
				end else if (req.position >= count_q) begin
					q_cmd.status = pida_pkg::ST_BADPOS;
				end else begin
					q_cmd.kind        = pida_pkg::CMD_DELETE;
					q_cmd.count_after = count_q - CW'(1);
				end
			end
			pida_pkg::OP_IDLE: begin
				q_cmd.kind = pida_pkg::CMD_NONE;
			end
			default: begin
				q_cmd.kind = pida_pkg::CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= q_cmd.count_after;
		end
	end

	`PIDA_ASSERT_NEXT(a_insert_count, q_push && q_cmd.kind == pida_pkg::CMD_INSERT, count_q == $past(count_q) + CW'(1), "insert beat did not raise the fill count")

endmodule

`default_nettype wire

// ----- hw/rtl/pida_cmdq.sv -----
// ----------------------------------------------------------------------------
// pida_cmdq
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_delete_array_macros.svh"

module pida_cmdq #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pida_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output pida_pkg::cmd_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	pida_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [NW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	`PIDA_ASSERT_NOW(a_no_overflow, push, !full, "command pushed into a full queue")
	`PIDA_ASSERT_NOW(a_no_underflow, pop, valid, "command popped from an empty queue")

endmodule

`default_nettype wire

// ----- hw/rtl/pida_back.sv -----
// ----------------------------------------------------------------------------
// pida_back
// Carry out queued commands on the entry RAM, one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_insert_delete_array_macros.svh"

module pida_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire pida_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  wire logic           pop,
	output pida_pkg::rsp_t      rsp
);

	localparam int AW = pida_pkg::ADDR_W;
	localparam int CW = pida_pkg::CNT_W;
	localparam int DW = pida_pkg::DATA_W;

	pida_pkg::bk_state_e state_q, state_d;
	pida_pkg::cmd_t      cur_q;
	logic [AW-1:0]       idx_q;
	logic [CW-1:0]       left_q;
	logic                first_q;
	logic [DW-1:0]       val_q;
	logic                res_valid_q;
	pida_pkg::rsp_t      res_q;

	logic                rd_v_s1;
	logic [AW-1:0]       rd_addr_s1;
	logic                rd_first_s1;

	logic                rd_en;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [DW-1:0]       wr_data;
	logic [DW-1:0]       rd_data;
	logic                capture;
	logic                res_load;
	logic                res_free;

	pida_ram #(
		.WIDTH (DW),
		.DEPTH (pida_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	assign res_free = !res_valid_q || pop;
	assign empty    = !res_valid_q;
	assign rsp      = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pida_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == pida_pkg::CMD_NONE) begin
						state_d = pida_pkg::BK_DONE;
					end else if (cmd.kind == pida_pkg::CMD_INSERT &&
						cmd.position == cmd.count_before) begin
						state_d = pida_pkg::BK_PLACE;
					end else begin
						state_d = pida_pkg::BK_SHIFT;
					end
				end
			end
			pida_pkg::BK_SHIFT: begin
				if (left_q == CW'(1)) begin
					state_d = pida_pkg::BK_DRAIN;
				end
			end
			pida_pkg::BK_DRAIN: begin
				state_d = (cur_q.kind == pida_pkg::CMD_INSERT) ?
					pida_pkg::BK_PLACE : pida_pkg::BK_DONE;
			end
			pida_pkg::BK_PLACE: begin
				state_d = pida_pkg::BK_DONE;
			end
			pida_pkg::BK_DONE: begin
				if (res_free) begin
					state_d = pida_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pida_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			pida_pkg::BK_IDLE:  cmd_pop  = cmd_valid;
			pida_pkg::BK_SHIFT: rd_en    = 1'b1;
			pida_pkg::BK_DRAIN: ;
			pida_pkg::BK_PLACE: ;
			pida_pkg::BK_DONE:  res_load = res_free;
			default: ;
		endcase

		capture = rd_v_s1 && (cur_q.kind == pida_pkg::CMD_READ ||
			(cur_q.kind == pida_pkg::CMD_DELETE && rd_first_s1));

		if (state_q == pida_pkg::BK_PLACE) begin
			wr_en   = 1'b1;
			wr_addr = cur_q.position[AW-1:0];
			wr_data = cur_q.value;
		end else begin
			wr_en   = rd_v_s1 && !capture;
			wr_addr = (cur_q.kind == pida_pkg::CMD_INSERT) ?
				rd_addr_s1 + AW'(1) : rd_addr_s1 - AW'(1);
			wr_data = rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q   <= cmd;
			first_q <= 1'b1;
			if (cmd.kind == pida_pkg::CMD_INSERT) begin
				idx_q <= AW'(cmd.count_before - CW'(1));
			end else begin
				idx_q <= cmd.position[AW-1:0];
			end
			if (cmd.kind == pida_pkg::CMD_READ) begin
				left_q <= CW'(1);
			end else begin
				left_q <= cmd.count_before - cmd.position;
			end
		end else if (rd_en) begin
			first_q <= 1'b0;
			left_q  <= left_q - CW'(1);
			idx_q   <= (cur_q.kind == pida_pkg::CMD_INSERT) ?
				idx_q - AW'(1) : idx_q + AW'(1);
		end
		if (cmd_pop) begin
			val_q <= '0;
		end else if (capture) begin
			val_q <= rd_data;
		end
		rd_addr_s1  <= idx_q;
		rd_first_s1 <= first_q;
		if (res_load) begin
			res_q.status     <= cur_q.status;
			res_q.value_out  <= val_q;
			res_q.fill_count <= cur_q.count_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pida_pkg::BK_IDLE;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`PIDA_ASSERT_NOW(a_place_port_free, state_q == pida_pkg::BK_PLACE, !rd_v_s1, "placement write collides with a shift write")
	`PIDA_ASSERT_NOW(a_drain_has_data, state_q == pida_pkg::BK_DRAIN, rd_v_s1, "drain cycle without read data")
	`PIDA_ASSERT_NOW(a_load_slot_free, res_load, !res_valid_q || pop, "result loaded over a waiting beat")

endmodule

`default_nettype wire

// ----- test/pida_checker.sv -----
// ----------------------------------------------------------------------------
// pida_checker
// Watches both queue sides of the positional insert/delete array, keeps a
// shadow copy of the entries and the fill count, and compares every result
// beat, field by field, against the oldest predicted response.
// ----------------------------------------------------------------------------
module pida_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  pida_pkg::req_t req,
	input  logic           empty,
	input  logic           pop,
	input  pida_pkg::rsp_t rsp,
	output int             fails,
	output int             pending
);

	logic signed [pida_pkg::DATA_W-1:0] shadow_cells [pida_pkg::CAPACITY];
	int                                 shadow_fill;
	pida_pkg::rsp_t                     awaited_rsp [$];
	int                                 miss_count;

	initial begin
		shadow_fill = 0;
		miss_count  = 0;
		fails       = 0;
		pending     = 0;
	end

	task automatic report(input string what);
		miss_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic apply_request(input pida_pkg::req_t r);
		pida_pkg::rsp_t want;
		int             pos;
		pos            = int'(r.position);
		want.status    = pida_pkg::ST_OK;
		want.value_out = '0;
		case (pida_pkg::op_e'(r.operation))
			pida_pkg::OP_READ: begin
				if (shadow_fill == 0)
					want.status = pida_pkg::ST_EMPTY;
				else if (pos >= shadow_fill)
					want.status = pida_pkg::ST_BADPOS;
				else
					want.value_out = shadow_cells[pos];
			end
			pida_pkg::OP_INSERT: begin
				if (shadow_fill >= pida_pkg::CAPACITY) begin
					want.status = pida_pkg::ST_FULL;
				end else if (pos > shadow_fill) begin
					want.status = pida_pkg::ST_BADPOS;
				end else begin
					for (int k = shadow_fill; k > pos; k--)
						shadow_cells[k] = shadow_cells[k-1];
					shadow_cells[pos] = r.value_in;
					shadow_fill++;
				end
			end
			pida_pkg::OP_DELETE: begin
				if (shadow_fill == 0) begin
					want.status = pida_pkg::ST_EMPTY;
				end else if (pos >= shadow_fill) begin
					want.status = pida_pkg::ST_BADPOS;
				end else begin
					want.value_out = shadow_cells[pos];
					for (int k = pos; k + 1 < shadow_fill; k++)
						shadow_cells[k] = shadow_cells[k+1];
					shadow_fill--;
				end
			end
			default: ;
		endcase
		want.fill_count = pida_pkg::CNT_W'(shadow_fill);
		awaited_rsp.push_back(want);
	endtask

	task automatic check_beat(input pida_pkg::rsp_t got);
		pida_pkg::rsp_t want;
		if (awaited_rsp.size() == 0) begin
			report($sformatf("result beat with nothing awaited (status %0d value %0d count %0d)",
				got.status, got.value_out, got.fill_count));
		end else begin
			want = awaited_rsp.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.value_out !== want.value_out)
				report($sformatf("value_out %0d, want %0d", got.value_out, want.value_out));
			if (got.fill_count !== want.fill_count)
				report($sformatf("fill_count %0d, want %0d", got.fill_count, want.fill_count));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_beat(rsp);
			if (push && !full)
				apply_request(req);
		end
		fails   <= miss_count;
		pending <= awaited_rsp.size();
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the positional insert/delete array with a short directed sequence
// and then random grow/shrink sweeps that fill the array to capacity and
// drain it to empty, with random gaps on both sides and two long result
// stalls. A checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;

	localparam int ITEMS        = 1350;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 500;

	logic           clk;
	logic           arst_n;
	logic           push;
	logic           full;
	logic           empty;
	logic           pop;
	pida_pkg::req_t req;
	pida_pkg::rsp_t rsp;

	int fails;
	int pending;
	int cycles     = 0;
	int items_sent = 0;
	int level      = 0;
	bit growing    = 1'b1;

	positional_insert_delete_array u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	pida_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic pida_pkg::req_t make_req(input pida_pkg::op_e op, input int pos,
		input logic [pida_pkg::DATA_W-1:0] v);
		pida_pkg::req_t r;
		r.operation = op;
		r.position  = pida_pkg::CNT_W'(pos);
		r.value_in  = v;
		return r;
	endfunction

	function automatic int pick_position(input int hi);
		int pick;
		pick = $urandom_range(0, 9);
		if (hi <= 0 || pick == 0)
			return 0;
		else if (pick == 1)
			return hi;
		else
			return $urandom_range(0, hi);
	endfunction

	function automatic pida_pkg::req_t random_req();
		pida_pkg::req_t r;
		pida_pkg::op_e  op;
		int             pick;
		pick       = $urandom_range(0, 99);
		r.value_in = $urandom;
		if (pick >= 82) begin
			r.operation = 2'($urandom_range(0, 3));
			if (pick < 91)
				r.position = pida_pkg::CNT_W'($urandom_range(0, 127));
			else
				r.position = pida_pkg::CNT_W'(level + $urandom_range(0, 2));
			return r;
		end
		if (pick < 65)
			op = growing ? pida_pkg::OP_INSERT : pida_pkg::OP_DELETE;
		else if (pick < 75)
			op = pida_pkg::OP_READ;
		else
			op = growing ? pida_pkg::OP_DELETE : pida_pkg::OP_INSERT;
		r.operation = op;
		r.position  = pida_pkg::CNT_W'(pick_position(op == pida_pkg::OP_INSERT ?
			level : level - 1));
		return r;
	endfunction

	task automatic send_beat(input pida_pkg::req_t r);
		int gap;
		int pos;
		gap = (items_sent % 100 < 30) ? 0 : idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		pos = int'(r.position);
		case (pida_pkg::op_e'(r.operation))
			pida_pkg::OP_INSERT: if (level < pida_pkg::CAPACITY && pos <= level) level++;
			pida_pkg::OP_DELETE: if (level > 0 && pos < level) level--;
			default: ;
		endcase
		items_sent++;
	endtask

	initial begin
		int gap;
		int popped;
		bit held_early;
		bit held_late;
		popped     = 0;
		held_early = 1'b0;
		held_late  = 1'b0;
		pop        = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ((!held_early && items_sent >= 200) || (!held_late && items_sent >= 900)) begin
				if (held_early)
					held_late = 1'b1;
				held_early = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = (popped % 80 < 25) ? 0 : idle_len();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			popped++;
		end
	end

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		req    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(make_req(pida_pkg::OP_READ,   0,   32'h1234_5678));
		send_beat(make_req(pida_pkg::OP_DELETE, 0,   32'hFFFF_FFFF));
		send_beat(make_req(pida_pkg::OP_IDLE,   127, 32'hFFFF_FFFF));
		send_beat(make_req(pida_pkg::OP_INSERT, 1,   32'h0000_0001));
		send_beat(make_req(pida_pkg::OP_INSERT, 0,   32'h8000_0000));
		send_beat(make_req(pida_pkg::OP_INSERT, 1,   32'h7FFF_FFFF));
		send_beat(make_req(pida_pkg::OP_INSERT, 0,   32'hFFFF_FFFF));
		send_beat(make_req(pida_pkg::OP_INSERT, 3,   32'h5A5A_5A5A));
		send_beat(make_req(pida_pkg::OP_INSERT, 5,   32'hA5A5_A5A5));
		send_beat(make_req(pida_pkg::OP_INSERT, 127, 32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_READ,   0,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_READ,   3,   32'hFFFF_FFFF));
		send_beat(make_req(pida_pkg::OP_READ,   4,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_READ,   127, 32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 4,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 64,  32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 1,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 0,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_IDLE,   0,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 1,   32'h0000_0000));
		send_beat(make_req(pida_pkg::OP_DELETE, 0,   32'h0000_0000));

		while (items_sent < ITEMS) begin
			send_beat(random_req());
			if (growing && level == pida_pkg::CAPACITY && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && level == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 199) == 0)
				growing = !growing;
		end
		push <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pida_pkg.sv
hw/rtl/pida_ram.sv
hw/rtl/pida_front.sv
hw/rtl/pida_cmdq.sv
hw/rtl/pida_back.sv
hw/rtl/positional_insert_delete_array.sv
test/pida_checker.sv
test/tb.sv
